// ----- hw/rtl/pkt_pkg.sv -----
// Shared types and constants for the passcode key table.
// Holds the command codes, stream widths and the result record.
// No dependencies.
`default_nettype none

package pkt_pkg;

    // Command codes carried in the low bits of the input item.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    // Field widths and stream packing.
    localparam int CMD_W     = 2;
    localparam int KEY_MAX_W = 64;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // One result item.
    typedef struct packed {
        logic table_empty;
        logic table_full;
        logic hit;
    } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pkt_out_reg.sv -----
// Output register for the passcode key table result stream.
// Holds one result item so the table can go on while it waits.
// Depends on pkt_pkg.
`default_nettype none

module pkt_out_reg (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              res_valid,
    output logic             res_ready,
    input  pkt_pkg::res_t    res_data,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [pkt_pkg::M_TDATA_W-1:0] m_tdata  // hit, table_full, table_empty, zeros
);
    import pkt_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    // The register can load when it is empty or being drained this cycle.
    assign res_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid && res_ready) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 3){1'b0}}, data_reg.table_empty,
                       data_reg.table_full, data_reg.hit};

endmodule

`default_nettype wire

// ----- hw/rtl/passcode_key_table.sv -----
// Top level of the passcode key table: busy marks, key memory and sequencer.
// Uses pkt_pkg and the result register pkt_out_reg.
//
//   Channel | Direction | Ports                       | Item
//   s_      | in        | s_tvalid s_tready s_tdata   | cmd [1:0], key [65:2]
//   m_      | out       | m_tvalid m_tready m_tdata   | hit [0], full [1], empty [2]
//
// Add, clear and status: taken in ST_IDLE, then ST_RESULT hands the result to the output
// register. Query: one slot a cycle through the registered key memory read and the compare
// stage until a hit or the last slot, then ST_RESULT. A new item is taken only in ST_IDLE.
// Reset frees every slot at once; key memory contents are not cleared.
// A result waiting on m_tready lets one more item run; that item's result then waits
// in the sequencer, which holds s_tready low.
`default_nettype none

module passcode_key_table #(
    parameter int SLOTS     = 8,
    parameter int KEY_BYTES = 8
) (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_tvalid,
    output logic s_tready,
    input  wire  [pkt_pkg::S_TDATA_W-1:0] s_tdata,  // cmd, key, zeros
    output logic m_tvalid,
    input  wire  m_tready,
    output logic [pkt_pkg::M_TDATA_W-1:0] m_tdata   // hit, table_full, table_empty, zeros
);
    import pkt_pkg::*;

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_QUERY  = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             hit_reg, hit_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] rd_data_reg;
    logic [KEY_W-1:0] key_mem [SLOTS];

    logic [CMD_W-1:0] in_cmd;
    logic [KEY_W-1:0] in_key;
    logic             s_fire;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] free_idx;
    logic             mem_we;
    logic             match;
    logic             res_valid;
    logic             res_ready;
    res_t             res_data;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_key   = s_tdata[CMD_W +: KEY_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign full  = &busy_reg;
    assign empty = ~|busy_reg;

    // Lowest-numbered free slot.
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Compare stage: the key read last cycle against the query key.
    assign match = cmp_vld_reg && busy_reg[cmp_idx_reg] && (rd_data_reg == key_reg);

    assign mem_we = s_fire && (in_cmd == CMD_ADD) && !full;

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        cmp_vld_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_fire) begin
                    hit_next   = 1'b0;
                    state_next = ST_RESULT;
                    case (in_cmd)
                        CMD_ADD: begin
                            if (!full) begin
                                busy_next[free_idx] = 1'b1;
                                hit_next            = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            state_next = ST_QUERY;
                        end
                        CMD_CLEAR: begin
                            busy_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                if (idx_reg != LAST_IDX) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (match || (cmp_vld_reg && cmp_idx_reg == LAST_IDX)) begin
                    hit_next   = match;
                    state_next = ST_RESULT;
                end else begin
                    cmp_vld_next = 1'b1;
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= idx_reg;
        hit_reg     <= hit_next;
        if (s_fire) begin
            key_reg <= in_key;
        end
    end

    // Key memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[free_idx] <= in_key;
        end
        rd_data_reg <= key_mem[idx_reg];
    end

    // Result, with flags taken after the operation.
    assign res_valid            = (state_reg == ST_RESULT);
    assign res_data.hit         = hit_reg;
    assign res_data.table_full  = full;
    assign res_data.table_empty = empty;

    pkt_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A hit can only be reported while some slot is busy.
    a_hit_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && hit_reg) |-> !empty)
        else $error("hit reported on an empty table");

    // An add on a table with room marks exactly one more slot busy.
    a_add_one_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_cmd == CMD_ADD && !full) |=>
        ($countones(busy_reg) == $past($countones(busy_reg)) + 1))
        else $error("add did not take exactly one slot");

    // Clear-all leaves every slot free.
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_cmd == CMD_CLEAR) |=> empty)
        else $error("clear left a busy slot");

endmodule

`default_nettype wire
